/* src/rsmp_pkg.sv */
package rsmp_pkg;

  localparam int DEF_PHASES         = 128;
  localparam int DEF_MAX_HALF_WIDTH = 31;
  localparam int DEF_HISTORY_DEPTH  = 64;

  localparam int COEF_COLS_W = 6;
  localparam int RUN_LIMIT   = 64;
  localparam int POS_W       = 48;
  localparam int STEP_W      = 19;
  localparam int HW_W        = 5;
  localparam int CFG_DATA_W  = 19;

  localparam logic [STEP_W-1:0] UNITY_STEP      = 19'd65536;
  localparam logic [STEP_W-1:0] RATIO_STEP_RST  = 19'd65536;
  localparam logic [HW_W-1:0]   HALF_WIDTH_RST  = 5'd8;

  typedef enum logic {
    CFG_RATIO_STEP = 1'b0,
    CFG_HALF_WIDTH = 1'b1
  } cfg_index_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEF   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               coef_ok;
    logic signed [15:0] sample;
    logic [6:0]         phase;
    logic [5:0]         tap;
    logic signed [17:0] value;
    logic               last;
  } item_t;

  typedef enum logic [1:0] {
    SEL_FIRST,
    SEL_NEWEST,
    SEL_RING
  } sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_CHECK,
    ST_TAPS,
    ST_DRAIN,
    ST_ROUND,
    ST_STORE,
    ST_SKIP,
    ST_FIN
  } state_t;

endpackage

/* src/rsmp_front.sv */
module rsmp_front import rsmp_pkg::*; #(
  parameter int PHASES = DEF_PHASES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_sample,
  input  logic [6:0]  in_phase,
  input  logic [5:0]  in_tap,
  input  logic [17:0] in_value,
  input  logic        in_last,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;
  logic       pop;

  // Classify: a coefficient write to a row that does not exist is dropped later.
  always_comb begin
    cls.kind    = kind_t'(in_kind);
    cls.coef_ok = (32'(in_phase) < PHASES);
    cls.sample  = $signed(in_sample);
    cls.phase   = in_phase;
    cls.tap     = in_tap;
    cls.value   = $signed(in_value);
    cls.last    = in_last;
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/rsmp_rem.sv */
module rsmp_rem import rsmp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [POS_W-1:0]  dividend,
  input  logic [STEP_W-1:0] divisor,
  output logic              done,
  output logic [STEP_W-1:0] remainder
);

  logic [POS_W-1:0]  dvd;
  logic [STEP_W-1:0] dsr;
  logic [STEP_W:0]   r_sh;
  logic [5:0]        cnt;
  logic              busy;

  // Restoring division, one dividend bit per cycle; only the remainder is kept.
  assign r_sh = {remainder, dvd[POS_W-1]};

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dsr       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[POS_W-2:0], 1'b0};
      if (r_sh >= {1'b0, dsr}) begin
        remainder <= STEP_W'(r_sh - {1'b0, dsr});
      end else begin
        remainder <= STEP_W'(r_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(POS_W - 1);
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/rsmp_back.sv */
module rsmp_back import rsmp_pkg::*; #(
  parameter int PHASES         = DEF_PHASES,
  parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
  parameter int HISTORY_DEPTH  = DEF_HISTORY_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [STEP_W-1:0] ratio_step,
  input  logic [HW_W-1:0]   hw_cfg,
  input  logic              q_valid,
  output logic              q_ready,
  input  item_t             q_item,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_sample,
  output logic              out_lor,
  output logic              out_eos,
  output logic              out_trunc
);

  localparam int PHW = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int CAW = PHW + COEF_COLS_W;

  state_t state, state_next;

  logic signed [15:0] ring [HISTORY_DEPTH];
  logic signed [17:0] coef_mem [PHASES * (1 << COEF_COLS_W)];

  logic [31:0]        samples_seen;
  logic [POS_W-1:0]   next_pos;
  logic signed [15:0] first_sample;
  logic signed [15:0] newest;
  logic [HAW-1:0]     wptr;
  logic               is_last;
  logic [6:0]         run_cnt;
  logic               trunc;
  logic               have_pend;
  logic [15:0]        pend;
  logic [15:0]        result;

  logic signed [33:0] idx;
  logic [HAW-1:0]     raddr;
  logic [5:0]         tap;
  logic               v1;
  logic               v2;
  sel_t               sel1;
  logic signed [15:0] ring_q;
  logic signed [17:0] coef_q;
  logic signed [33:0] prod;
  logic signed [39:0] acc;

  logic [HW_W-1:0]    hw;
  logic [31:0]        center;
  logic [26:0]        phase_prod;
  logic [PHW-1:0]     phase;
  logic               rdy;
  logic signed [33:0] s0;
  logic signed [33:0] n_m1;
  logic [POS_W-1:0]   target;
  logic [STEP_W-1:0]  adj;
  logic               out_free;
  sel_t               sel;
  logic signed [15:0] samp;
  logic signed [40:0] rsum;
  logic signed [24:0] rsh;

  logic              rem_start;
  logic [POS_W-1:0]  rem_dividend;
  logic [STEP_W-1:0] rem_divisor;
  logic              rem_done;
  logic [STEP_W-1:0] rem_val;

  logic        emit;
  logic [15:0] emit_data;
  logic        emit_lor;
  logic        emit_eos;
  logic        emit_trunc;

  rsmp_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (rem_dividend),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_val)
  );

  assign hw         = (32'(hw_cfg) < MAX_HALF_WIDTH) ? hw_cfg
                                                      : HW_W'(MAX_HALF_WIDTH);
  assign center     = next_pos[POS_W-1:16];
  assign phase_prod = {11'd0, next_pos[15:0]} * 27'(PHASES);
  assign phase      = phase_prod[16 +: PHW];
  assign s0         = $signed({2'b00, center}) - $signed(34'(hw));
  assign n_m1       = $signed({2'b00, samples_seen}) - 34'sd1;
  assign target     = {samples_seen - 32'(hw), 16'd0};
  assign adj        = (rem_val == '0) ? '0 : ratio_step - rem_val;
  assign out_free   = !out_valid || out_ready;

  // An output is ready once its right edge has arrived, or at the end of the
  // stream once its whole step lies inside the stream.
  always_comb begin
    if (is_last) begin
      rdy = ({1'b0, next_pos} + 49'(ratio_step)) <= {1'b0, samples_seen, 16'd0};
    end else begin
      rdy = ({1'b0, center} + 33'(hw)) < {1'b0, samples_seen};
    end
  end

  // Reads past the newest sample take the newest one, reads at or before the
  // first index take the first sample of the stream.
  always_comb begin
    if (idx > n_m1) begin
      sel = (n_m1 == 34'sd0) ? SEL_FIRST : SEL_NEWEST;
    end else if (idx <= 34'sd0) begin
      sel = SEL_FIRST;
    end else begin
      sel = SEL_RING;
    end
  end

  always_comb begin
    unique case (sel1)
      SEL_FIRST:  samp = first_sample;
      SEL_NEWEST: samp = newest;
      SEL_RING:   samp = ring_q;
      default:    samp = first_sample;
    endcase
  end

  assign rsum = 41'(acc) + 41'sd32768;
  assign rsh  = 25'(rsum >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    q_ready      = 1'b0;
    rem_start    = 1'b0;
    rem_dividend = '0;
    rem_divisor  = '0;
    emit         = 1'b0;
    emit_data    = pend;
    emit_lor     = 1'b0;
    emit_eos     = 1'b0;
    emit_trunc   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid && q_item.kind == KIND_SAMPLE) begin
          state_next = (ratio_step == UNITY_STEP) ? ST_PASS : ST_CHECK;
        end
      end
      ST_PASS: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_data  = newest;
          emit_lor   = 1'b1;
          emit_eos   = is_last;
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (rdy && run_cnt < 7'(RUN_LIMIT)) begin
          state_next = ST_TAPS;
        end else if (rdy && !is_last && ratio_step != '0) begin
          rem_start    = 1'b1;
          rem_dividend = target - next_pos;
          rem_divisor  = ratio_step;
          state_next   = ST_SKIP;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_TAPS: begin
        if (tap == {hw, 1'b0}) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        state_next = ST_STORE;
      end
      ST_STORE: begin
        if (!have_pend || out_free) begin
          emit       = have_pend;
          state_next = ST_CHECK;
        end
      end
      ST_SKIP: begin
        if (rem_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!have_pend) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_lor   = 1'b1;
          emit_eos   = is_last;
          emit_trunc = trunc;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid) begin
      if (q_item.kind == KIND_COEF && q_item.coef_ok) begin
        coef_mem[{PHW'(q_item.phase), q_item.tap}] <= q_item.value;
      end
      if (q_item.kind == KIND_SAMPLE) begin
        ring[wptr] <= q_item.sample;
      end
    end
    coef_q <= coef_mem[CAW'({phase, tap})];
    ring_q <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
      next_pos     <= '0;
      first_sample <= '0;
      wptr         <= '0;
      have_pend    <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      v1 <= (state == ST_TAPS);
      v2 <= v1;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid && q_item.kind == KIND_SAMPLE) begin
            if (samples_seen == '0) begin
              first_sample <= q_item.sample;
            end
            wptr         <= (wptr == HAW'(HISTORY_DEPTH - 1)) ? '0 : wptr + HAW'(1);
            samples_seen <= samples_seen + 32'd1;
            have_pend    <= 1'b0;
          end
        end
        ST_STORE: begin
          if (!have_pend || out_free) begin
            have_pend <= 1'b1;
            next_pos  <= next_pos + POS_W'(ratio_step);
          end
        end
        ST_SKIP: begin
          if (rem_done) begin
            next_pos <= target + POS_W'(adj);
          end
        end
        default: begin
        end
      endcase
      // The end of the stream clears the position and the sample count.
      if (state_next == ST_IDLE && (state == ST_PASS || state == ST_FIN) && is_last) begin
        samples_seen <= '0;
        next_pos     <= '0;
        first_sample <= '0;
        wptr         <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_item.kind == KIND_SAMPLE) begin
      newest  <= q_item.sample;
      is_last <= q_item.last;
      run_cnt <= '0;
      trunc   <= 1'b0;
    end
    if (state == ST_CHECK) begin
      idx <= s0;
      tap <= '0;
      acc <= '0;
      // The ring depth is a power of two, so the low bits give the ring slot.
      raddr <= s0[HAW-1:0];
      if (rdy && run_cnt == 7'(RUN_LIMIT)) begin
        trunc <= 1'b1;
      end
    end
    if (state == ST_TAPS) begin
      sel1 <= sel;
      idx  <= idx + 34'sd1;
      tap  <= tap + 6'd1;
      if (idx <= 34'sd0) begin
        raddr <= HAW'(1);
      end else begin
        raddr <= (raddr == HAW'(HISTORY_DEPTH - 1)) ? '0 : raddr + HAW'(1);
      end
    end
    if (v1) begin
      prod <= samp * coef_q;
    end
    if (v2) begin
      acc <= acc + 40'(prod);
    end
    if (state == ST_ROUND) begin
      if (rsh > 25'sd32767) begin
        result <= 16'h7FFF;
      end else if (rsh < -25'sd32768) begin
        result <= 16'h8000;
      end else begin
        result <= rsh[15:0];
      end
    end
    if (state == ST_STORE && (!have_pend || out_free)) begin
      pend    <= result;
      run_cnt <= run_cnt + 7'd1;
    end
    if (emit) begin
      out_sample <= emit_data;
      out_lor    <= emit_lor;
      out_eos    <= emit_eos;
      out_trunc  <= emit_trunc;
    end
  end

endmodule

/* src/polyphase_sinc_resampler_unit.sv */
// Polyphase FIR sample rate converter.
// Input stream s_axis: tuser = 1 writes one coefficient (phase row, tap column,
// value) into the table and gives no output; tuser = 0 is an audio sample, with
// tlast on the final sample of a stream. Output stream m_axis carries resampled
// values; tlast marks the final output caused by one input transaction.
// Configuration: cfg_we writes cfg_data to the register chosen by cfg_index
// (0 ratio step in Q3.16, 1 filter half width). The user must write it only
// while the block is idle; the block itself does not enforce this. A two-entry
// queue takes input while the filter engine works. Each output reads one tap a
// cycle from the coefficient memory, then drains the pipeline, rounds and hands
// over. Each sample also adds an entry step and a final hand-over. A unity
// step passes each sample straight through. A live item (not the last) that
// overruns the 64-output limit also passes through the serial divider that
// finds where to skip ahead.
// Reset clears the queue, the position and the sample count; the coefficient
// table and history ring are not cleared. When m_axis stalls, the engine waits
// with its finished output and the queue then fills and drops s_axis_tready.
module polyphase_sinc_resampler_unit import rsmp_pkg::*; #(
  parameter int PHASES         = DEF_PHASES,
  parameter int MAX_HALF_WIDTH = DEF_MAX_HALF_WIDTH,
  parameter int HISTORY_DEPTH  = DEF_HISTORY_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // sample_in, coef_phase, coef_tap, coef_value
  input  logic                  s_axis_tuser,  // kind
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // sample_out
  output logic [1:0]            m_axis_tuser,  // end_of_stream, tail_truncated
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [STEP_W-1:0] ratio_step;
  logic [HW_W-1:0]   hw_cfg;
  logic              q_valid;
  logic              q_ready;
  item_t             q_item;
  logic              eos;
  logic              trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_step <= RATIO_STEP_RST;
      hw_cfg     <= HALF_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RATIO_STEP: ratio_step <= cfg_data;
        CFG_HALF_WIDTH: hw_cfg <= cfg_data[HW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rsmp_front #(
    .PHASES (PHASES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_sample (s_axis_tdata[15:0]),
    .in_phase  (s_axis_tdata[22:16]),
    .in_tap    (s_axis_tdata[28:23]),
    .in_value  (s_axis_tdata[46:29]),
    .in_last   (s_axis_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  rsmp_back #(
    .PHASES         (PHASES),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
    .HISTORY_DEPTH  (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ratio_step (ratio_step),
    .hw_cfg     (hw_cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (m_axis_tdata),
    .out_lor    (m_axis_tlast),
    .out_eos    (eos),
    .out_trunc  (trunc)
  );

  assign m_axis_tuser = {trunc, eos};

`ifndef SYNTH
  a_rst_no_output: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
  a_eos_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("end of stream not on the final output of the transaction");
  a_trunc_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
    else $error("truncation flag not on the final output of the transaction");
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready) |=> q_valid)
    else $error("queued item lost while the engine was busy");
`endif

endmodule

/* tb/tb_polyphase_sinc_resampler_unit.sv */
module tb_polyphase_sinc_resampler_unit;
  import rsmp_pkg::*;

  localparam int      CLK_HALF    = 10;
  localparam int      TBL_PHASES  = 128;
  localparam int      TBL_TAPS    = 64;
  localparam int      RING_DEPTH  = 64;
  localparam int      HW_LIMIT    = 31;
  localparam int      SETTLE      = 300;
  localparam longint  CYCLE_LIMIT = 3000000;
  localparam longint unsigned POS_MASK = (64'd1 << POS_W) - 1;

  typedef struct {
    kind_t              kind;
    logic signed [15:0] sample;
    logic [6:0]         phase;
    logic [5:0]         tap;
    logic signed [17:0] value;
    logic               last;
  } src_item_t;

  typedef struct {
    logic [15:0] sample_out;
    logic        last_of_run;
    logic        end_of_stream;
    logic        tail_truncated;
  } rs_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;  // sample_in, coef_phase, coef_tap, coef_value
  logic                  s_axis_tuser = 1'b0;  // kind
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;  // sample_out
  logic [1:0]            m_axis_tuser;  // end_of_stream, tail_truncated
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  cfg_index_t            cfg_index = CFG_RATIO_STEP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  polyphase_sinc_resampler_unit dut (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Shadow of the block's state, kept by the predictor.
  logic signed [17:0] coef_tbl [TBL_PHASES][TBL_TAPS];
  logic signed [15:0] hist [RING_DEPTH];
  logic signed [15:0] first_smp = '0;
  logic [31:0]        seen = '0;
  longint unsigned    next_pos = 0;
  logic [STEP_W-1:0]  step_reg = RATIO_STEP_RST;
  logic [HW_W-1:0]    hw_reg = HALF_WIDTH_RST;

  src_item_t pending_q[$];
  rs_out_t   expected_q[$];
  src_item_t on_bus;

  int  errors = 0;
  int  n_samples = 0, n_coefs = 0, n_outputs = 0, n_trunc = 0, n_eos = 0;
  bit  quiet = 1'b0;
  int  gap_left = 0, stall_left = 0, hold_left = 0;
  bit  hold_done = 1'b0;
  longint cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch on output %0d: %s got %0d expected %0d", n_outputs, what, got, want);
  endtask

  function automatic logic signed [15:0] sample_at(input longint idx, input longint n);
    if (n > 0 && idx > n - 1) idx = n - 1;
    if (idx <= 0) return first_smp;
    return hist[idx % RING_DEPTH];
  endfunction

  function automatic logic [15:0] fir_at(input longint unsigned p, input longint n,
                                         input int hw);
    longint centre;
    int     ph, tap;
    longint acc;
    longint v;
    centre = longint'(p >> 16);
    ph = int'(((p & 64'hFFFF) * TBL_PHASES) >> 16);
    acc = 0;
    for (int j = -hw; j <= hw; j++) begin
      tap = j + hw;
      if (tap < TBL_TAPS)
        acc += longint'(sample_at(centre + j, n)) * longint'(coef_tbl[ph][tap]);
    end
    v = (acc + 32768) >>> 16;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic bit out_ready(input longint unsigned p, input longint unsigned n,
                                   input int hw, input longint unsigned step, input bit last);
    if (last) return p + step <= (n << 16);
    return (p >> 16) + hw < n;
  endfunction

  task automatic resample_item(input src_item_t it);
    longint unsigned n, p, step, target, skip;
    int  hw, cnt;
    bit  trunc;
    rs_out_t r;
    if (it.kind == KIND_COEF) begin
      coef_tbl[it.phase][it.tap] = it.value;
      n_coefs++;
      return;
    end
    n_samples++;
    if (seen == 0) first_smp = it.sample;
    hist[seen % RING_DEPTH] = it.sample;
    seen++;
    n = seen;
    hw = (hw_reg < HW_LIMIT) ? hw_reg : HW_LIMIT;
    step = step_reg;
    trunc = 1'b0;
    if (step_reg == UNITY_STEP) begin
      r = '{it.sample, 1'b1, it.last, 1'b0};
      expected_q.push_back(r);
    end else begin
      p = next_pos;
      cnt = 0;
      while (cnt < RUN_LIMIT && out_ready(p, n, hw, step, it.last)) begin
        r = '{fir_at(p, n, hw), 1'b0, 1'b0, 1'b0};
        expected_q.push_back(r);
        p = (p + step) & POS_MASK;
        cnt++;
      end
      if (cnt == RUN_LIMIT && out_ready(p, n, hw, step, it.last)) begin
        trunc = 1'b1;
        // A live stream jumps to the first output whose right edge is still missing.
        if (!it.last && step != 0) begin
          target = (n - hw) << 16;
          skip = (target - p + step - 1) / step;
          p = (p + skip * step) & POS_MASK;
        end
      end
      next_pos = p;
      if (cnt > 0) begin
        expected_q[$].last_of_run = 1'b1;
        expected_q[$].end_of_stream = it.last;
        expected_q[$].tail_truncated = trunc;
      end
    end
    if (it.last) begin
      seen = '0;
      next_pos = 0;
      first_smp = '0;
    end
  endtask

  // Sender: offers items from the pending queue, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) resample_item(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
          on_bus = pending_q.pop_front();
          s_axis_tdata <= {1'b0, on_bus.value, on_bus.tap, on_bus.phase, on_bus.sample};
          s_axis_tuser <= on_bus.kind;
          s_axis_tlast <= on_bus.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          if (pending_q.size() > 0) gap_left <= $urandom_range(1, 10) - 1;
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each output transaction and stalls at random.
  always @(posedge clk) begin
    rs_out_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_outputs++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("output %0d arrived with nothing expected", n_outputs);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata !== want.sample_out)
            report_mismatch("sample_out", $signed(m_axis_tdata), $signed(want.sample_out));
          if (m_axis_tlast !== want.last_of_run)
            report_mismatch("last_of_run", m_axis_tlast, want.last_of_run);
          if (m_axis_tuser[0] !== want.end_of_stream)
            report_mismatch("end_of_stream", m_axis_tuser[0], want.end_of_stream);
          if (m_axis_tuser[1] !== want.tail_truncated)
            report_mismatch("tail_truncated", m_axis_tuser[1], want.tail_truncated);
          if (want.tail_truncated) n_trunc++;
          if (want.end_of_stream) n_eos++;
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && m_axis_tvalid && pending_q.size() >= 4) begin
        // One long hold-off while items are still coming, so that the input stalls.
        hold_done <= 1'b1;
        hold_left <= 1500;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 10) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[polyphase_sinc_resampler_unit] ERROR");
      $finish;
    end
  end

  task automatic push_sample(input logic signed [15:0] s, input logic last);
    src_item_t it;
    it = '{KIND_SAMPLE, s, 7'($urandom), 6'($urandom), 18'($urandom), last};
    pending_q.push_back(it);
  endtask

  task automatic push_coef(input int ph, input int tap, input logic signed [17:0] v);
    src_item_t it;
    it = '{KIND_COEF, 16'($urandom), ph[6:0], tap[5:0], v, 1'($urandom)};
    pending_q.push_back(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0) @(negedge clk);
    // Coefficient writes give no output, so let the engine finish them too.
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    if (idx == CFG_RATIO_STEP) step_reg = value[STEP_W-1:0];
    else hw_reg = value[HW_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_stream(input int len);
    logic signed [15:0] s;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        push_coef($urandom_range(0, TBL_PHASES - 1), $urandom_range(0, TBL_TAPS - 1),
                  ($urandom_range(0, 3) == 0) ? 18'($urandom)
                                              : 18'($urandom_range(0, 16383) - 8192));
      case ($urandom_range(0, 15))
        0:       s = 16'sh7FFF;
        1:       s = 16'sh8000;
        default: s = 16'($urandom);
      endcase
      push_sample(s, k == len - 1);
    end
  endtask

  initial begin
    int steps [6];
    int total;
    steps = '{16384, 262144, 49152, 65536, 98304, 81920};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every step is a multiple of a quarter sample, so only four phase rows are
    // ever read; load those over every tap that the widest filter uses.
    @(negedge clk);
    for (int ph = 0; ph < TBL_PHASES; ph += TBL_PHASES / 4)
      for (int tp = 0; tp <= 2 * HW_LIMIT; tp++)
        push_coef(ph, tp, 18'($urandom_range(0, 16383) - 8192));
    push_coef(0, 0, 18'sh1FFFF);
    push_coef(TBL_PHASES - 1, TBL_TAPS - 1, 18'sh20000);
    // Unity step at reset: samples pass straight through.
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(16'sh0001, 1'b1);
    wait_idle();

    // A last item alone at a wide step yields nothing; then a short stream.
    write_reg(CFG_RATIO_STEP, 262144);
    write_reg(CFG_HALF_WIDTH, HW_LIMIT);
    @(negedge clk);
    push_sample(16'sh1234, 1'b1);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'shFFFF, 1'b1);
    wait_idle();

    // Quarter step at the widest filter: the tail on last overruns the run limit.
    write_reg(CFG_RATIO_STEP, 16384);
    @(negedge clk);
    random_stream(24);
    wait_idle();

    // Narrowing the filter mid-stream makes one item overrun and skip ahead.
    @(negedge clk);
    for (int k = 0; k < 24; k++) push_sample(16'($urandom), 1'b0);
    wait_idle();
    write_reg(CFG_HALF_WIDTH, 1);
    @(negedge clk);
    for (int k = 0; k < 6; k++) push_sample(16'($urandom), k == 5);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_RATIO_STEP, (ph < 6) ? steps[ph] : 16384 * $urandom_range(1, 16));
      write_reg(CFG_HALF_WIDTH, (ph % 3 == 0) ? 1 : (ph % 3 == 1) ? HW_LIMIT
                                               : $urandom_range(1, HW_LIMIT));
      if (ph == 7) quiet <= 1'b1;
      @(negedge clk);
      total = 0;
      while (total < 10) begin
        int len;
        len = $urandom_range(1, 6);
        random_stream(len);
        total += len;
      end
      wait_idle();
    end

    $display("covered %0d samples and %0d coefficient writes over eight random settings",
             n_samples, n_coefs);
    $display("checked %0d outputs, %0d stream ends, %0d truncated runs",
             n_outputs, n_eos, n_trunc);
    if (errors == 0) begin
      $display("[polyphase_sinc_resampler_unit] OK");
    end else begin
      $display("[polyphase_sinc_resampler_unit] ERROR");
    end
    $finish;
  end

endmodule
